### rtl/core/tte_pkg.sv
// shared types and codes for the transposition table engine
`default_nettype none

package tte_pkg;

   // operation codes
   localparam logic OP_PROBE  = 1'b0;
   localparam logic OP_RECORD = 1'b1;

   // bound kinds
   localparam logic [1:0] BOUND_EXACT = 2'd0;
   localparam logic [1:0] BOUND_UPPER = 2'd1;
   localparam logic [1:0] BOUND_LOWER = 2'd2;

   localparam int KEY_BITS   = 64;
   localparam int DEPTH_BITS = 4;
   localparam int BOUND_BITS = 2;
   localparam int PORT_SCORE_BITS = 32;

   // control states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // outcome of evaluating one beat against its table entry
   typedef struct packed {
      logic                              hit;
      logic                              stored;
      logic                              wr_en;
      logic signed [PORT_SCORE_BITS-1:0] score;
   } eval_type;

endpackage

`default_nettype wire

### rtl/core/tte_ram.sv
// generic single-port-write, registered-read synchronous ram
`default_nettype none

module tte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/core/tte_eval.sv
// probe and record evaluation of one beat against the entry read back
`default_nettype none

module tte_eval
   import tte_pkg::*;
#(
   parameter int SCORE_BITS = 32
) (
   input  wire logic                              operation,
   input  wire logic [KEY_BITS-1:0]               position_key,
   input  wire logic [DEPTH_BITS-1:0]             ply_depth,
   input  wire logic signed [PORT_SCORE_BITS-1:0] entry_score,
   input  wire logic signed [PORT_SCORE_BITS-1:0] alpha_bound,
   input  wire logic signed [PORT_SCORE_BITS-1:0] beta_bound,
   input  wire logic                              e_valid,
   input  wire logic [KEY_BITS-1:0]               e_key,
   input  wire logic signed [SCORE_BITS-1:0]      e_score,
   input  wire logic [BOUND_BITS-1:0]             e_bound,
   input  wire logic [DEPTH_BITS-1:0]             e_depth,
   output eval_type                               result,
   output logic signed [SCORE_BITS-1:0]           sat_score
);

   logic signed [PORT_SCORE_BITS-1:0] score_hi;
   logic                              score_fits;
   logic signed [PORT_SCORE_BITS-1:0] e_score_ext;
   logic                              probe_match;
   logic                              keep_deeper;

   // saturate the incoming score to the stored width
   always_comb begin
      score_hi   = entry_score >>> (SCORE_BITS - 1);
      score_fits = (score_hi == '0) || (score_hi == '1);
      if (score_fits) begin
         sat_score = entry_score[SCORE_BITS-1:0];
      end else if (entry_score[PORT_SCORE_BITS-1]) begin
         sat_score = {1'b1, {(SCORE_BITS-1){1'b0}}};
      end else begin
         sat_score = {1'b0, {(SCORE_BITS-1){1'b1}}};
      end
   end

   // entry tests and bound selection
   always_comb begin
      e_score_ext = PORT_SCORE_BITS'(e_score);
      probe_match = e_valid && (e_key == position_key) && (e_depth <= ply_depth);
      keep_deeper = e_valid && (e_depth > ply_depth);
      result      = '0;
      if (operation == OP_RECORD) begin
         result.wr_en  = !keep_deeper;
         result.stored = !keep_deeper;
      end else if (probe_match) begin
         case (e_bound)
            BOUND_EXACT: begin
               result.hit   = 1'b1;
               result.score = e_score_ext;
            end
            BOUND_UPPER: begin
               if (e_score_ext <= alpha_bound) begin
                  result.hit   = 1'b1;
                  result.score = alpha_bound;
               end
            end
            BOUND_LOWER: begin
               if (e_score_ext >= beta_bound) begin
                  result.hit   = 1'b1;
                  result.score = beta_bound;
               end
            end
            default: begin
               result.hit = 1'b0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### rtl/core/transposition_table_engine.sv
// top level of the depth-preferred direct-mapped transposition table
`default_nettype none

// Every beat runs the accept edge, which launches the table read and latches
// the request, and then ST_LOOKUP, which evaluates the entry and writes it
// back, so busy is high for one cycle after each accept and a new beat is
// taken only after the last one has been written back. The result is
// registered from ST_LOOKUP and driven on the rsp_ ports, marked by
// rsp_strobe, for one cycle; it cannot be held off by the receiver. After
// reset the table runs a clearing pass over all 2^INDEX_BITS entries (65536
// at the default) with busy high. The table is one memory with one read and
// one write port.
module transposition_table_engine
   import tte_pkg::*;
#(
   parameter int INDEX_BITS = 16,
   parameter int SCORE_BITS = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_operation,
   input  wire logic [KEY_BITS-1:0]               req_position_key,
   input  wire logic [DEPTH_BITS-1:0]             req_ply_depth,
   input  wire logic signed [PORT_SCORE_BITS-1:0] req_entry_score,
   input  wire logic [BOUND_BITS-1:0]             req_bound_kind,
   input  wire logic signed [PORT_SCORE_BITS-1:0] req_alpha_bound,
   input  wire logic signed [PORT_SCORE_BITS-1:0] req_beta_bound,
   output logic                                   rsp_strobe,
   output logic                                   rsp_hit,
   output logic signed [PORT_SCORE_BITS-1:0]      rsp_result_score,
   output logic                                   rsp_stored
);

   localparam int DEPTH     = 1 << INDEX_BITS;
   localparam int ENTRY_BITS = 1 + KEY_BITS + SCORE_BITS + BOUND_BITS + DEPTH_BITS;

   state_type state_ff, state_in;

   logic [INDEX_BITS-1:0] clr_addr_ff, clr_addr_in;

   // latched request beat
   logic                              op_ff;
   logic [KEY_BITS-1:0]               key_ff;
   logic [DEPTH_BITS-1:0]             depth_ff;
   logic signed [PORT_SCORE_BITS-1:0] score_ff;
   logic [BOUND_BITS-1:0]             kind_ff;
   logic signed [PORT_SCORE_BITS-1:0] alpha_ff;
   logic signed [PORT_SCORE_BITS-1:0] beta_ff;

   logic rsp_strobe_ff, rsp_strobe_in;
   logic rsp_hit_ff;
   logic signed [PORT_SCORE_BITS-1:0] rsp_score_ff;
   logic rsp_stored_ff;

   logic                  accept;
   logic                  mem_wr_en;
   logic [INDEX_BITS-1:0] mem_wr_addr;
   logic [ENTRY_BITS-1:0] mem_wr_data;
   logic [ENTRY_BITS-1:0] mem_rd_data;

   logic                              e_valid;
   logic [KEY_BITS-1:0]               e_key;
   logic signed [SCORE_BITS-1:0]      e_score;
   logic [BOUND_BITS-1:0]             e_bound;
   logic [DEPTH_BITS-1:0]             e_depth;
   eval_type                          eval;
   logic signed [SCORE_BITS-1:0]      sat_score;

   assign accept = start && !busy;
   assign {e_valid, e_key, e_score, e_bound, e_depth} = mem_rd_data;

   // table memory: valid, key, score, bound, depth in one word
   tte_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (accept),
      .rd_addr (req_position_key[INDEX_BITS-1:0]),
      .rd_data (mem_rd_data)
   );

   // evaluation of the latched beat against the entry
   tte_eval #(
      .SCORE_BITS (SCORE_BITS)
   ) u_eval (
      .operation    (op_ff),
      .position_key (key_ff),
      .ply_depth    (depth_ff),
      .entry_score  (score_ff),
      .alpha_bound  (alpha_ff),
      .beta_bound   (beta_ff),
      .e_valid      (e_valid),
      .e_key        (e_key),
      .e_score      (e_score),
      .e_bound      (e_bound),
      .e_depth      (e_depth),
      .result       (eval),
      .sat_score    (sat_score)
   );

   // next state
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // state outputs: handshake and table write port
   always_comb begin
      busy          = 1'b1;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = key_ff[INDEX_BITS-1:0];
      mem_wr_data   = {1'b1, key_ff, sat_score, kind_ff, depth_ff};
      rsp_strobe_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            mem_wr_data = '0;
         end
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_LOOKUP: begin
            mem_wr_en     = eval.wr_en;
            rsp_strobe_in = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // request beat capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_operation;
         key_ff   <= req_position_key;
         depth_ff <= req_ply_depth;
         score_ff <= req_entry_score;
         kind_ff  <= req_bound_kind;
         alpha_ff <= req_alpha_bound;
         beta_ff  <= req_beta_bound;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOOKUP) begin
         rsp_hit_ff    <= eval.hit;
         rsp_score_ff  <= eval.score;
         rsp_stored_ff <= eval.stored;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_result_score = rsp_score_ff;
   assign rsp_stored       = rsp_stored_ff;

endmodule

`default_nettype wire
